// ===== rtl/core/assert_macros.svh =====
// Assertion helpers shared by the sorter modules.
// Each expects clk and arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/csl_pkg.sv =====
package csl_pkg;

	localparam int LAYER_W  = 4;
	localparam int KEY_W    = 32;
	localparam int HANDLE_W = 16;
	localparam int REC_W    = LAYER_W + KEY_W + HANDLE_W;
	localparam int TDATA_W  = ((REC_W + 7) / 8) * 8;
	localparam int CFG_W    = 5;
	localparam int HCNT_W   = 7;
	localparam int PADDR_W  = 4;

	localparam logic [1:0]       REG_LAYER_COUNT = 2'd0;
	localparam logic [CFG_W-1:0] LC_RESET        = 5'd16;

	// controller -> datapath
	typedef struct packed {
		logic load;      // item accepted this cycle
		logic pfx_step;  // one prefix-sum step
		logic pl_issue;  // issue one placement read
		logic em_cap;    // capture sorted entry into output register
		logic em_next;   // advance emit pointer
		logic clear;     // clear histogram, count and overflow
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic pfx_last;
		logic empty;
		logic pl_last;
		logic em_last;
		logic out_busy;
		logic out_take;
	} sts_t;

endpackage

// ===== rtl/core/counting_sort_by_layer_top.sv =====
// Load: one item per cycle while s_tready is high (load state only).
// After the item with tlast: prefix steps (one histogram bin per cycle,
// HIST_N = min(MAX_LAYERS,16)), then n placement reads and a drain state.
// Emit: each result passes sorted store read, capture and handshake; the next
// result is read only after the previous one is taken.
// Reset: control, histogram, count, overflow cleared; layer_count = 16; stores not cleared.
module counting_sort_by_layer_top #(
	parameter int MAX_RECORDS = 64,
	parameter int MAX_LAYERS  = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// input stream
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [csl_pkg::TDATA_W-1:0]   s_tdata,   // layer[3:0], record_key[35:4], handle[51:36]
	input  logic                          s_tlast,   // last_item
	// output stream
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [csl_pkg::TDATA_W-1:0]   m_tdata,   // out_layer[3:0], out_key[35:4], out_handle[51:36]
	output logic                          m_tlast,   // last_result
	output logic                          m_tuser,   // overflow
	// register port
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [csl_pkg::PADDR_W-1:0]   paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);
	import csl_pkg::*;

	logic [CFG_W-1:0] layer_count_q;
	logic [REC_W-1:0] out_rec;
	cmd_t             cmd;
	sts_t             sts;

	// register file: only layer_count, at word 0; other words read zero
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			layer_count_q <= LC_RESET;
		end else if (psel && penable && pwrite && pready
			&& (paddr[PADDR_W-1:2] == REG_LAYER_COUNT)) begin
			layer_count_q <= pwdata[CFG_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[PADDR_W-1:2] == REG_LAYER_COUNT) begin
			prdata = {{(32-CFG_W){1'b0}}, layer_count_q};
		end
	end

	// sequencer: load, prefix, place, emit
	csl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tlast  (s_tlast),
		.s_tready (s_tready),
		.cmd      (cmd),
		.sts      (sts)
	);

	// histogram, record and sorted stores, output register
	csl_dp #(
		.MAX_RECORDS (MAX_RECORDS),
		.MAX_LAYERS  (MAX_LAYERS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.layer_count (layer_count_q),
		.in_rec      (s_tdata[REC_W-1:0]),
		.out_rec     (out_rec),
		.out_last    (m_tlast),
		.out_ovf     (m_tuser),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.cmd         (cmd),
		.sts         (sts)
	);

	// tdata padded with zeros up to whole bytes
	assign m_tdata = {{(TDATA_W-REC_W){1'b0}}, out_rec};

endmodule

// ===== rtl/core/csl_ram.sv =====
module csl_ram #(
	parameter int WIDTH = 52,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== rtl/core/csl_ctrl.sv =====
`include "assert_macros.svh"

module csl_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	input  logic          s_tlast,
	output logic          s_tready,
	output csl_pkg::cmd_t cmd,
	input  csl_pkg::sts_t sts
);
	import csl_pkg::*;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_PREFIX,
		ST_PLACE,
		ST_DRAIN,
		ST_EMIT_RD,
		ST_EMIT_CAP,
		ST_EMIT_OUT
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_LOAD: begin
				cmd.load = s_tvalid;
				if (s_tvalid && s_tlast) begin
					state_d = ST_PREFIX;
				end
			end
			ST_PREFIX: begin
				cmd.pfx_step = 1'b1;
				if (sts.pfx_last) begin
					if (sts.empty) begin
						cmd.clear = 1'b1;
						state_d   = ST_LOAD;
					end else begin
						state_d = ST_PLACE;
					end
				end
			end
			ST_PLACE: begin
				cmd.pl_issue = 1'b1;
				if (sts.pl_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_EMIT_RD;
			end
			ST_EMIT_RD: begin
				state_d = ST_EMIT_CAP;
			end
			ST_EMIT_CAP: begin
				cmd.em_cap = 1'b1;
				state_d    = ST_EMIT_OUT;
			end
			ST_EMIT_OUT: begin
				if (sts.out_take) begin
					cmd.em_next = 1'b1;
					if (sts.em_last) begin
						cmd.clear = 1'b1;
						state_d   = ST_LOAD;
					end else begin
						state_d = ST_EMIT_RD;
					end
				end
			end
			default: begin
				state_d = ST_LOAD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	assign s_tready = (state_q == ST_LOAD);

	`ASSERT_IMPL(a_no_load_while_out, s_tready, !sts.out_busy, "load while output held")
	`ASSERT_NEXT(a_emit_ends_in_load, (state_q == ST_EMIT_OUT) && sts.out_take && sts.em_last, s_tready, "final item did not return to load")

endmodule

// ===== rtl/core/csl_dp.sv =====
`include "assert_macros.svh"

module csl_dp #(
	parameter int MAX_RECORDS = 64,
	parameter int MAX_LAYERS  = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic [csl_pkg::CFG_W-1:0]       layer_count,
	input  logic [csl_pkg::REC_W-1:0]       in_rec,
	output logic [csl_pkg::REC_W-1:0]       out_rec,
	output logic                            out_last,
	output logic                            out_ovf,
	output logic                            out_valid,
	input  logic                            out_ready,
	input  csl_pkg::cmd_t                   cmd,
	output csl_pkg::sts_t                   sts
);
	import csl_pkg::*;

	// layers are 4 bits wide, so at most 16 histogram bins ever see a count
	localparam int HIST_N     = (MAX_LAYERS < 16) ? MAX_LAYERS : 16;
	localparam int HIST_IDX_W = $clog2(HIST_N);
	localparam int CNT_W      = $clog2(MAX_RECORDS + 1);
	localparam int IDX_W      = $clog2(MAX_RECORDS);
	localparam logic [CFG_W-1:0] HIST_N_C = CFG_W'(HIST_N);
	localparam logic [CNT_W-1:0] MAX_C    = CNT_W'(MAX_RECORDS);

	logic [HCNT_W-1:0]     hist_q [HIST_N];
	logic [CNT_W-1:0]      cnt_q;
	logic                  ovf_q;
	logic [HCNT_W-1:0]     acc_q;
	logic [HIST_IDX_W-1:0] hp_q;
	logic [IDX_W-1:0]      pl_q;
	logic [IDX_W-1:0]      em_q;
	logic                  vld_s1;
	logic [REC_W-1:0]      out_rec_q;
	logic                  out_last_q, out_ovf_q, out_vld_q;

	logic [CFG_W-1:0]      eff;
	logic [LAYER_W-1:0]    lay_sat;
	logic                  full;
	logic [HCNT_W-1:0]     pfx_sum;
	logic [REC_W-1:0]      rs_rdata, ss_rdata;
	logic [HIST_IDX_W-1:0] pl_bin;
	logic [HCNT_W-1:0]     pos;
	logic                  take;

	// saturate layer against the effective layer count
	always_comb begin
		if (layer_count == '0) begin
			eff = CFG_W'(1);
		end else if (layer_count > HIST_N_C) begin
			eff = HIST_N_C;
		end else begin
			eff = layer_count;
		end
		if ({1'b0, in_rec[LAYER_W-1:0]} >= eff) begin
			lay_sat = LAYER_W'(eff - CFG_W'(1));
		end else begin
			lay_sat = in_rec[LAYER_W-1:0];
		end
	end

	assign full    = (cnt_q == MAX_C);
	assign pfx_sum = hist_q[hp_q] + acc_q;
	assign pl_bin  = rs_rdata[HIST_IDX_W-1:0];
	assign pos     = (hist_q[pl_bin] == '0) ? '0 : hist_q[pl_bin] - HCNT_W'(1);
	assign take    = out_vld_q && out_ready;

	csl_ram #(.WIDTH(REC_W), .DEPTH(MAX_RECORDS)) u_rec_ram (
		.clk   (clk),
		.we    (cmd.load && !full),
		.waddr (cnt_q[IDX_W-1:0]),
		.wdata ({in_rec[REC_W-1:LAYER_W], lay_sat}),
		.raddr (pl_q),
		.rdata (rs_rdata)
	);

	csl_ram #(.WIDTH(REC_W), .DEPTH(MAX_RECORDS)) u_sort_ram (
		.clk   (clk),
		.we    (vld_s1),
		.waddr (pos[IDX_W-1:0]),
		.wdata (rs_rdata),
		.raddr (em_q),
		.rdata (ss_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < HIST_N; i++) begin
				hist_q[i] <= '0;
			end
			cnt_q  <= '0;
			ovf_q  <= 1'b0;
			acc_q  <= '0;
			hp_q   <= '0;
			pl_q   <= '0;
			em_q   <= '0;
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= cmd.pl_issue;
			if (cmd.clear) begin
				for (int i = 0; i < HIST_N; i++) begin
					hist_q[i] <= '0;
				end
				cnt_q <= '0;
				ovf_q <= 1'b0;
			end else if (cmd.load) begin
				if (full) begin
					ovf_q <= 1'b1;
				end else begin
					hist_q[lay_sat[HIST_IDX_W-1:0]] <= hist_q[lay_sat[HIST_IDX_W-1:0]] + HCNT_W'(1);
					cnt_q <= cnt_q + CNT_W'(1);
				end
			end else if (cmd.pfx_step) begin
				hist_q[hp_q] <= pfx_sum;
			end else if (vld_s1) begin
				hist_q[pl_bin] <= pos;
			end

			if (cmd.pfx_step) begin
				if (sts.pfx_last) begin
					hp_q  <= '0;
					acc_q <= '0;
				end else begin
					hp_q  <= hp_q + HIST_IDX_W'(1);
					acc_q <= pfx_sum;
				end
				pl_q <= IDX_W'(cnt_q - CNT_W'(1));
				em_q <= '0;
			end else if (cmd.pl_issue) begin
				pl_q <= pl_q - IDX_W'(1);
			end

			if (cmd.em_next) begin
				em_q <= em_q + IDX_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (cmd.em_cap) begin
			out_vld_q <= 1'b1;
		end else if (take) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.em_cap) begin
			out_rec_q  <= ss_rdata;
			out_last_q <= sts.em_last;
			out_ovf_q  <= ovf_q;
		end
	end

	always_comb begin
		sts.pfx_last = (hp_q == HIST_IDX_W'(HIST_N - 1));
		sts.empty    = (cnt_q == '0);
		sts.pl_last  = (pl_q == '0);
		sts.em_last  = ((CNT_W'(em_q) + CNT_W'(1)) == cnt_q);
		sts.out_busy = out_vld_q;
		sts.out_take = take;
	end

	assign out_rec   = out_rec_q;
	assign out_last  = out_last_q;
	assign out_ovf   = out_ovf_q;
	assign out_valid = out_vld_q;

	`ASSERT_IMPL(a_pos_nonzero, vld_s1, hist_q[pl_bin] != '0, "placement bin already exhausted")
	`ASSERT_IMPL(a_cnt_range, 1'b1, cnt_q <= MAX_C, "record count beyond capacity")

endmodule
